@@ hw/rtl/sqvr_pkg.sv @@
// ----------------------------------------------------------------------------
// sqvr_pkg: shared constants and helpers
// Fixed-point constants, arctangent table and saturation helper for the
// sprite quad vertex rotation block.
// ----------------------------------------------------------------------------
package sqvr_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;

    localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [35:0] Q30_GAIN    = 36'sd652032874;

    // Corner codes, output order.
    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BR = 2'd2;
    localparam logic [1:0] CORNER_BL = 2'd3;

    localparam logic [1:0] PIVOT_NEG  = 2'd0;
    localparam logic [1:0] PIVOT_ZERO = 2'd1;

    function automatic logic signed [35:0] atan_q30(input int i);
        logic signed [35:0] v;
        case (i)
            0: v = 36'sd843314856;
            1: v = 36'sd497837829;
            2: v = 36'sd263043836;
            3: v = 36'sd133525158;
            4: v = 36'sd67021686;
            5: v = 36'sd33543515;
            6: v = 36'sd16775850;
            7: v = 36'sd8388437;
            8: v = 36'sd4194282;
            9: v = 36'sd2097149;
            10: v = 36'sd1048575;
            11: v = 36'sd524287;
            12: v = 36'sd262143;
            13: v = 36'sd131071;
            14: v = 36'sd65535;
            15: v = 36'sd32767;
            16: v = 36'sd16383;
            17: v = 36'sd8191;
            18: v = 36'sd4095;
            19: v = 36'sd2047;
            20: v = 36'sd1023;
            21: v = 36'sd511;
            22: v = 36'sd255;
            23: v = 36'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Pivot code to -1/0/+1 as a 2-bit signed value.
    function automatic logic signed [1:0] pivot_of(input logic [1:0] code);
        logic signed [1:0] p;
        case (code)
            PIVOT_NEG:  p = -2'sd1;
            PIVOT_ZERO: p = 2'sd0;
            default:    p = 2'sd1;
        endcase
        return p;
    endfunction

endpackage

@@ hw/rtl/sqvr_cordic.sv @@
// ----------------------------------------------------------------------------
// sqvr_cordic: pipelined half-angle sine and cosine
// Range-reduce a Q3 angle to Q30, fold into +-pi/2, then one rotation stage
// per register.
// ----------------------------------------------------------------------------
module sqvr_cordic import sqvr_pkg::*; #(
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [15:0]            i_angle,
    output logic signed [35:0]            o_sin,
    output logic signed [35:0]            o_cos
);
    localparam int NS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    // Largest magnitude of the scaled angle, and the whole turns it may need.
    localparam longint ZMAX  = longint'(1) << (47 - ANGLE_BITS);
    localparam int     NWRAP = (ZMAX > longint'(Q30_PI)) ?
        int'((ZMAX - longint'(Q30_PI) + longint'(Q30_TWO_PI) - 1) / longint'(Q30_TWO_PI))
        : 0;

    logic signed [35:0] r_x [NS+1];
    logic signed [35:0] r_y [NS+1];
    logic signed [35:0] r_z [NS+1];
    logic               r_neg [NS+1];
    logic signed [35:0] n_z;
    logic               n_neg;

    // Reduce: remove whole turns until the angle lies within +-pi; with the
    // default format the input never leaves that range.
    always_comb begin
        logic signed [35:0] z;
        z = 36'(i_angle) <<< (32 - ANGLE_BITS);
        for (int k = 0; k < NWRAP; k++) begin
            if (z > Q30_PI) begin
                z = z - Q30_TWO_PI;
            end else if (z < -Q30_PI) begin
                z = z + Q30_TWO_PI;
            end
        end
        n_neg = 1'b0;
        if (z > Q30_HALF_PI) begin
            z = Q30_PI - z;
            n_neg = 1'b1;
        end else if (z < -Q30_HALF_PI) begin
            z = -Q30_PI - z;
            n_neg = 1'b1;
        end
        n_z = z;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= Q30_GAIN;
            r_y[0]   <= '0;
            r_z[0]   <= n_z;
            r_neg[0] <= n_neg;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[i+1] <= r_neg[i];
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_q30(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_q30(i);
                end
            end
        end
    end

    assign o_sin = r_y[NS];
    assign o_cos = r_neg[NS] ? -r_x[NS] : r_x[NS];

endmodule

@@ hw/rtl/sprite_quad_vertex_rotation.sv @@
// ----------------------------------------------------------------------------
// sprite_quad_vertex_rotation: rotate the four corners of a sprite quad
// Euler angles to quaternion, rotate pivot-offset corners, add position.
// ----------------------------------------------------------------------------
// One sprite beat in yields four vertex beats out (TL, TR, BR, BL; last on BL).
// The sprite input is free only while the serializer holds no earlier sprite's
// corners or is feeding the last one, and it emits one corner per cycle while
// the output is not stalled. The path runs through the CORDIC depth
// (min(CORDIC_STEPS,24)+1 stages), quaternion stages 1 and 2, the alignment
// stages, the serializer hold and rotation stages A, B and C. The sprite
// pipeline advances on adv and the rotation pipe on out_free; a stall on the
// output freezes both without loss.
module sprite_quad_vertex_rotation import sqvr_pkg::*; #(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [31:0]   i_size_x,
    input  logic signed [31:0]   i_size_y,
    input  logic signed [15:0]   i_scale_x,
    input  logic signed [15:0]   i_scale_y,
    input  logic signed [15:0]   i_angle_x,
    input  logic signed [15:0]   i_angle_y,
    input  logic signed [15:0]   i_angle_z,
    input  logic signed [31:0]   i_center_x,
    input  logic signed [31:0]   i_center_y,
    input  logic [1:0]           i_h_pivot,
    input  logic [1:0]           i_v_pivot,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_corner,
    output logic signed [31:0]   o_vert_x,
    output logic signed [31:0]   o_vert_y,
    output logic signed [31:0]   o_vert_z,
    output logic                 o_last
);
    // Coordinate format does not change any operation.
    localparam int NS    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int CDLY  = NS + 1;
    localparam int DEPTH = CDLY + 4;

    // Pipeline moves whenever the output stage can load a new sprite.
    logic       adv;
    logic [1:0] r_cnt;
    logic       r_busy;

    // ---------------- geometry side path ----------------
    logic signed [31:0] r_xs0, r_xs1, r_ys0, r_ys1;
    logic signed [31:0] n_xs0, n_xs1, n_ys0, n_ys1;
    logic signed [47:0] r_ex_p, r_ey_p;
    logic signed [1:0]  r_ph, r_pv;
    logic signed [31:0] r_sx, r_sy, r_cx, r_cy;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ex_p <= 48'(i_size_x) * 48'(i_scale_x) + 48'sd128;
            r_ey_p <= 48'(i_size_y) * 48'(i_scale_y) + 48'sd128;
            r_ph   <= pivot_of(i_h_pivot);
            r_pv   <= pivot_of(i_v_pivot);
            r_sx   <= i_size_x;
            r_sy   <= i_size_y;
            r_cx   <= i_center_x;
            r_cy   <= i_center_y;
        end
    end

    always_comb begin
        logic signed [39:0] hx, hy;
        hx = 40'(r_ex_p >>> 9);
        hy = 40'(r_ey_p >>> 9);
        n_xs0 = sat32(-hx - hx * 40'(r_ph));
        n_xs1 = sat32(hx - hx * 40'(r_ph));
        n_ys0 = sat32(-hy - hy * 40'(r_pv));
        n_ys1 = sat32(hy - hy * 40'(r_pv));
    end

    // Delay line for corner offsets to meet the quaternion.
    logic signed [31:0] r_gd [DEPTH-1][4];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_gd[0][0] <= n_xs0;
            r_gd[0][1] <= n_xs1;
            r_gd[0][2] <= n_ys0;
            r_gd[0][3] <= n_ys1;
            for (int i = 1; i < DEPTH - 1; i++) begin
                r_gd[i] <= r_gd[i-1];
            end
        end
    end
    // Translation may exceed 32 bits; keep full width separately.
    logic signed [39:0] r_ld [DEPTH-1][2];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ld[0][0] <= 40'(r_cx) + 40'(r_sx >>> 1) * 40'(r_ph);
            r_ld[0][1] <= 40'(r_cy) + 40'(r_sy >>> 1) * 40'(r_pv);
            for (int i = 1; i < DEPTH - 1; i++) begin
                r_ld[i] <= r_ld[i-1];
            end
        end
    end
    assign r_xs0 = r_gd[DEPTH-2][0];
    assign r_xs1 = r_gd[DEPTH-2][1];
    assign r_ys0 = r_gd[DEPTH-2][2];
    assign r_ys1 = r_gd[DEPTH-2][3];

    // ---------------- quaternion path ----------------
    logic signed [35:0] sa, ca, sb, cb, sc, cc;
    sqvr_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_ca (
        .i_clk(i_clk), .i_en(adv), .i_angle(i_angle_x), .o_sin(sa), .o_cos(ca));
    sqvr_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cb (
        .i_clk(i_clk), .i_en(adv), .i_angle(i_angle_y), .o_sin(sb), .o_cos(cb));
    sqvr_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cc (
        .i_clk(i_clk), .i_en(adv), .i_angle(i_angle_z), .o_sin(sc), .o_cos(cc));

    // The half-angle sine and cosine fit 32 bits; products fit 64.
    function automatic logic signed [35:0] rnd30(input logic signed [71:0] v);
        logic signed [71:0] t;
        t = (v + 72'sd536870912) >>> 30;
        return t[35:0];
    endfunction

    // qab = qa*qb: qa=(sa,0,0,ca), qb=(0,sb,0,cb). Stage 1.
    logic signed [35:0] r_ab [4];
    logic signed [35:0] r_c1s, r_c1c;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ab[0] <= rnd30(72'(cb) * 72'(sa));
            r_ab[1] <= rnd30(72'(ca) * 72'(sb));
            r_ab[2] <= rnd30(72'(sa) * 72'(sb));
            r_ab[3] <= rnd30(72'(ca) * 72'(cb));
            r_c1s   <= sc;
            r_c1c   <= cc;
        end
    end
    // q = qab*qc, qc=(0,0,sc,cc). Stage 2.
    logic signed [35:0] r_q [4];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_q[0] <= rnd30(72'(r_ab[0]) * 72'(r_c1c) + 72'(r_ab[1]) * 72'(r_c1s));
            r_q[1] <= rnd30(72'(r_ab[1]) * 72'(r_c1c) - 72'(r_ab[0]) * 72'(r_c1s));
            r_q[2] <= rnd30(72'(r_ab[3]) * 72'(r_c1s) + 72'(r_ab[2]) * 72'(r_c1c));
            r_q[3] <= rnd30(72'(r_ab[3]) * 72'(r_c1c) - 72'(r_ab[2]) * 72'(r_c1s));
        end
    end
    // Two more alignment stages so the quaternion meets the geometry delay.
    logic signed [35:0] r_q2 [4];
    logic signed [35:0] r_q3 [4];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_q2 <= r_q;
            r_q3 <= r_q2;
        end
    end

    // ---------------- output serializer ----------------
    // Hold one sprite's quaternion and corners; rotate one corner a cycle while the output is not stalled.
    // The valid of the sprite that reaches the serializer travels in r_vd.
    logic [DEPTH-1:0] r_vd;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= '0;
        end else if (adv) begin
            r_vd <= {r_vd[DEPTH-2:0], i_valid};
        end
    end

    logic signed [35:0] r_hq [4];
    logic signed [31:0] r_hxs0, r_hxs1, r_hys0, r_hys1;
    logic signed [39:0] r_hlx, r_hly;
    logic               load;

    assign load = r_vd[DEPTH-1] && adv;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_hq   <= r_q3;
            r_hxs0 <= r_xs0;
            r_hxs1 <= r_xs1;
            r_hys0 <= r_ys0;
            r_hys1 <= r_ys1;
            r_hlx  <= r_ld[DEPTH-2][0];
            r_hly  <= r_ld[DEPTH-2][1];
        end
    end

    // Corner sequencing: each corner moves through a 3-stage rotation pipe.
    logic       r_cv;
    logic       emit_stage;
    logic [2:0] r_rv;
    logic [1:0] r_rc [3];
    logic       out_free;

    assign out_free  = !r_rv[2] || !i_stall;
    // Feed a corner when the holding register has one left and the pipe moves.
    assign emit_stage = r_busy && out_free;
    assign adv       = out_free && (!r_busy || (r_cnt == CORNER_BL));
    assign r_cv      = emit_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= CORNER_TL;
        end else begin
            if (emit_stage) begin
                r_cnt <= r_cnt + 2'd1;
            end
            if (load) begin
                r_busy <= 1'b1;
            end else if (emit_stage && r_cnt == CORNER_BL) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Stage A: t = q*p (p has x,y only).
    logic signed [35:0] px, py;
    assign px = 36'((r_cnt == CORNER_TR || r_cnt == CORNER_BR) ? r_hxs1 : r_hxs0);
    assign py = 36'((r_cnt == CORNER_BR || r_cnt == CORNER_BL) ? r_hys1 : r_hys0);

    logic signed [35:0] r_t [4];
    logic signed [35:0] r_tq [4];
    logic signed [39:0] r_tl [2];
    always_ff @(posedge i_clk) begin
        if (out_free && r_cv) begin
            r_t[0] <= rnd30(72'(r_hq[3]) * 72'(px) - 72'(r_hq[2]) * 72'(py));
            r_t[1] <= rnd30(72'(r_hq[3]) * 72'(py) + 72'(r_hq[2]) * 72'(px));
            r_t[2] <= rnd30(72'(r_hq[0]) * 72'(py) - 72'(r_hq[1]) * 72'(px));
            r_t[3] <= rnd30(-72'(r_hq[0]) * 72'(px) - 72'(r_hq[1]) * 72'(py));
            r_tq   <= r_hq;
            r_tl[0] <= r_hlx;
            r_tl[1] <= r_hly;
        end
    end

    // Stage B: r = t*conj(q), x,y,z only.
    logic signed [71:0] rx, ry, rz;
    logic signed [35:0] cx, cy, cz, cw;
    assign cx = -r_tq[0];
    assign cy = -r_tq[1];
    assign cz = -r_tq[2];
    assign cw = r_tq[3];
    assign rx = 72'(r_t[3]) * 72'(cx) + 72'(cw) * 72'(r_t[0])
              + 72'(r_t[1]) * 72'(cz) - 72'(r_t[2]) * 72'(cy);
    assign ry = 72'(r_t[3]) * 72'(cy) + 72'(cw) * 72'(r_t[1])
              + 72'(r_t[2]) * 72'(cx) - 72'(r_t[0]) * 72'(cz);
    assign rz = 72'(r_t[3]) * 72'(cz) + 72'(cw) * 72'(r_t[2])
              + 72'(r_t[0]) * 72'(cy) - 72'(r_t[1]) * 72'(cx);

    logic signed [35:0] r_r [3];
    logic signed [39:0] r_rl [2];
    always_ff @(posedge i_clk) begin
        if (out_free && r_rv[0]) begin
            r_r[0]  <= rnd30(rx);
            r_r[1]  <= rnd30(ry);
            r_r[2]  <= rnd30(rz);
            r_rl    <= r_tl;
        end
    end

    // Stage C: add translation and saturate into the output register.
    logic signed [31:0] r_ox, r_oy, r_oz;
    always_ff @(posedge i_clk) begin
        if (out_free && r_rv[1]) begin
            r_ox <= sat32(40'(r_r[0]) + r_rl[0]);
            r_oy <= sat32(40'(r_r[1]) + r_rl[1]);
            r_oz <= sat32(40'(r_r[2]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= '0;
        end else if (out_free) begin
            r_rv <= {r_rv[1:0], r_cv};
        end
    end
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_rc[0] <= r_cnt;
            r_rc[1] <= r_rc[0];
            r_rc[2] <= r_rc[1];
        end
    end

    assign o_stall  = !adv;
    assign o_valid  = r_rv[2];
    assign o_corner = r_rc[2];
    assign o_vert_x = r_ox;
    assign o_vert_y = r_oy;
    assign o_vert_z = r_oz;
    assign o_last   = (r_rc[2] == CORNER_BL);

endmodule

@@ hw/rtl/sqvr_checker.sv @@
// ----------------------------------------------------------------------------
// sqvr_checker: port-level checks
// Last flag, corner order and stall behavior seen at the ports.
// ----------------------------------------------------------------------------
module sqvr_checker import sqvr_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_corner,
    input logic        o_last,
    input logic signed [31:0] o_vert_x
);
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_corner == CORNER_BL)))
        else $error("last not on final corner");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_vert_x) && $stable(o_corner))
        else $error("stalled beat changed");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_corner != CORNER_BL ##1 o_valid |->
        o_corner == $past(o_corner) + 2'd1)
        else $error("corner order broken");
endmodule

bind sprite_quad_vertex_rotation sqvr_checker u_sqvr_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_corner(o_corner), .o_last(o_last), .o_vert_x(o_vert_x));

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sprite_quad_vertex_rotation
// Sends sprites through the valid/stall input, computes the four expected
// vertices of each sprite with a bit-accurate model of its own, and compares
// every vertex beat that leaves the block against them, in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NUM_RANDOM = 310;

    typedef struct packed {
        logic signed [31:0] size_x;
        logic signed [31:0] size_y;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [1:0]         h_pivot;
        logic [1:0]         v_pivot;
    } t_sprite;

    typedef struct packed {
        logic [1:0]         corner;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               last;
    } t_vertex;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall_dut;
    t_sprite     spr = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  o_corner;
    logic signed [31:0] o_x, o_y, o_z;
    logic        o_last;

    t_sprite sprite_q[$];     // sprites waiting to be sent
    t_vertex vertex_q[$];     // vertices predicted, not yet seen
    int      n_sent = 0;
    int      n_seen = 0;
    int      n_errors = 0;
    int      n_cycles = 0;
    bit      stim_done = 1'b0;

    always #10 clk = ~clk;

    sprite_quad_vertex_rotation i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (in_stall_dut),
        .i_size_x   (spr.size_x),
        .i_size_y   (spr.size_y),
        .i_scale_x  (spr.scale_x),
        .i_scale_y  (spr.scale_y),
        .i_angle_x  (spr.angle_x),
        .i_angle_y  (spr.angle_y),
        .i_angle_z  (spr.angle_z),
        .i_center_x (spr.center_x),
        .i_center_y (spr.center_y),
        .i_h_pivot  (spr.h_pivot),
        .i_v_pivot  (spr.v_pivot),
        .o_valid    (out_valid),
        .i_stall    (out_stall),
        .o_corner   (o_corner),
        .o_vert_x   (o_x),
        .o_vert_y   (o_y),
        .o_vert_z   (o_z),
        .o_last     (o_last)
    );

    // ---------------------------------------------------------------- model
    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint pivot_sign(logic [1:0] code);
        // code 3 behaves like +1
        if (code == 2'd0) return -1;
        if (code == 2'd1) return 0;
        return 1;
    endfunction

    function automatic longint round_q30(longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint atan_step(int i);
        longint tbl[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
            33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
            262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
            255, 127};
        return tbl[i];
    endfunction

    // Hamilton product, components x, y, z, w; wraparound sums are intended.
    function automatic void quat_mul(input longint a[4], input longint b[4],
                                     output longint r[4]);
        longint x, y, z, w;
        x = a[3] * b[0] + b[3] * a[0] + a[1] * b[2] - a[2] * b[1];
        y = a[3] * b[1] + b[3] * a[1] + a[2] * b[0] - a[0] * b[2];
        z = a[3] * b[2] + b[3] * a[2] + a[0] * b[1] - a[1] * b[0];
        w = a[3] * b[3] - a[0] * b[0] - a[1] * b[1] - a[2] * b[2];
        r[0] = round_q30(x);
        r[1] = round_q30(y);
        r[2] = round_q30(z);
        r[3] = round_q30(w);
    endfunction

    // Half-angle sine and cosine in Q2.30: the Q3.13 angle read as Q3.29
    // is already the half angle in Q30.
    function automatic void half_angle_sc(input logic signed [15:0] ang,
                                          output longint s, output longint c);
        longint z, x, y, nx;
        bit flip;
        z = longint'(ang) * 65536;
        x = 64'sd652032874;
        y = 0;
        flip = 1'b0;
        while (z > 64'sd3373259426) z -= 64'sd6746518852;
        while (z < -64'sd3373259426) z += 64'sd6746518852;
        if (z > 64'sd1686629713) begin
            z = 64'sd3373259426 - z;
            flip = 1'b1;
        end else if (z < -64'sd1686629713) begin
            z = -64'sd3373259426 - z;
            flip = 1'b1;
        end
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_step(i);
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_step(i);
            end
            x = nx;
        end
        s = y;
        c = flip ? -x : x;
    endfunction

    task automatic predict_vertices(input t_sprite sp);
        longint ph, pv, ex, ey, hx, hy, lx, ly;
        longint xs[2], ys[2];
        longint qa[4], qb[4], qc[4], qab[4], q[4], qcj[4], p[4], t[4], r[4];
        t_vertex v;
        ph = pivot_sign(sp.h_pivot);
        pv = pivot_sign(sp.v_pivot);
        ex = (longint'(sp.size_x) * longint'(sp.scale_x) + 128) >>> 8;
        ey = (longint'(sp.size_y) * longint'(sp.scale_y) + 128) >>> 8;
        hx = ex >>> 1;
        hy = ey >>> 1;
        xs[0] = clamp32(-hx - hx * ph);
        xs[1] = clamp32(hx - hx * ph);
        ys[0] = clamp32(-hy - hy * pv);
        ys[1] = clamp32(hy - hy * pv);
        qa = '{0, 0, 0, 0};
        qb = '{0, 0, 0, 0};
        qc = '{0, 0, 0, 0};
        half_angle_sc(sp.angle_x, qa[0], qa[3]);
        half_angle_sc(sp.angle_y, qb[1], qb[3]);
        half_angle_sc(sp.angle_z, qc[2], qc[3]);
        quat_mul(qa, qb, qab);
        quat_mul(qab, qc, q);
        qcj = '{-q[0], -q[1], -q[2], q[3]};
        lx = longint'(sp.center_x) + (longint'(sp.size_x) >>> 1) * ph;
        ly = longint'(sp.center_y) + (longint'(sp.size_y) >>> 1) * pv;
        for (int k = 0; k < 4; k++) begin
            p = '{xs[(k == 1 || k == 2) ? 1 : 0], ys[(k >= 2) ? 1 : 0], 0, 0};
            quat_mul(q, p, t);
            quat_mul(t, qcj, r);
            v.corner = 2'(k);
            v.x = 32'(clamp32(r[0] + lx));
            v.y = 32'(clamp32(r[1] + ly));
            v.z = 32'(clamp32(r[2]));
            v.last = (k == 3);
            vertex_q.push_back(v);
        end
    endtask

    // ------------------------------------------------------------- stimulus
    function automatic logic signed [15:0] rand_angle();
        return 16'(int'($urandom_range(51472)) - 25736);
    endfunction

    function automatic logic signed [31:0] rand_coord();
        // mostly moderate sizes, sometimes the full 32-bit range
        if ($urandom_range(3) == 0) return $urandom;
        return 32'(int'($urandom_range(32'h01ff_ffff)) - 32'h0100_0000);
    endfunction

    function automatic t_sprite rand_sprite();
        t_sprite s;
        s.size_x   = rand_coord();
        s.size_y   = rand_coord();
        s.scale_x  = ($urandom_range(3) == 0) ? 16'($urandom) :
                     16'(int'($urandom_range(1024)) - 512);
        s.scale_y  = ($urandom_range(3) == 0) ? 16'($urandom) :
                     16'(int'($urandom_range(1024)) - 512);
        s.angle_x  = rand_angle();
        s.angle_y  = rand_angle();
        s.angle_z  = rand_angle();
        s.center_x = rand_coord();
        s.center_y = rand_coord();
        s.h_pivot  = 2'($urandom_range(3));
        s.v_pivot  = 2'($urandom_range(3));
        return s;
    endfunction

    function automatic t_sprite make_sprite(int sx, int sy, shortint kx, shortint ky,
                                            shortint ax, shortint ay, shortint az,
                                            int cx, int cy, int hp, int vp);
        t_sprite s;
        s = '{sx, sy, kx, ky, ax, ay, az, cx, cy, 2'(hp), 2'(vp)};
        return s;
    endfunction

    initial begin
        // zero sprite, identity rotation
        sprite_q.push_back(make_sprite(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
        // unit scale, every pivot code including the undefined one
        for (int h = 0; h < 4; h++)
            sprite_q.push_back(make_sprite(32'h0010_0000, 32'h0008_0000, 256, 256,
                                           0, 0, 0, 32'h0100_0000, -32'h0080_0000,
                                           h, 3 - h));
        // angle extremes on each axis, and near a quarter turn
        sprite_q.push_back(make_sprite(32'h0004_0000, 32'h0004_0000, 256, 256,
                                       25736, 0, 0, 0, 0, 0, 2));
        sprite_q.push_back(make_sprite(32'h0004_0000, 32'h0004_0000, 256, 256,
                                       0, -25736, 0, 0, 0, 2, 0));
        sprite_q.push_back(make_sprite(32'h0004_0000, 32'h0004_0000, 256, 256,
                                       0, 0, 25736, 0, 0, 1, 1));
        sprite_q.push_back(make_sprite(32'h0004_0000, 32'h0004_0000, 256, 256,
                                       -25736, 25736, -25736, 0, 0, 0, 0));
        sprite_q.push_back(make_sprite(32'h0004_0000, 32'h0002_0000, 512, -256,
                                       12868, 12869, -12869, 100, -100, 2, 2));
        // saturation: largest sizes and scales, extreme centers
        sprite_q.push_back(make_sprite(32'h7fff_ffff, 32'h7fff_ffff, 32767, 32767,
                                       0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0));
        sprite_q.push_back(make_sprite(32'h8000_0000, 32'h8000_0000, -32768, -32768,
                                       0, 0, 0, 32'h8000_0000, 32'h8000_0000, 2, 2));
        sprite_q.push_back(make_sprite(32'h8000_0000, 32'h7fff_ffff, 32767, -32768,
                                       20000, -20000, 9000, 32'h8000_0000,
                                       32'h7fff_ffff, 3, 3));
        sprite_q.push_back(make_sprite(-1, 1, -1, 1, 1, -1, 1, -1, 1, 0, 2));
        for (int i = 0; i < NUM_RANDOM; i++)
            sprite_q.push_back(rand_sprite());
        stim_done = 1'b1;
    end

    // --------------------------------------------------------------- driver
    // Advance to the next sprite only when the current beat was taken or no
    // beat is on offer; hold the payload while stalled.
    always @(posedge clk) begin
        n_cycles <= n_cycles + 1;
        if (rst_n) begin
            if (in_valid && !in_stall_dut) begin
                predict_vertices(spr);
                n_sent <= n_sent + 1;
            end
            if (!in_valid || !in_stall_dut) begin
                // no idling for a stretch of sprites in the middle
                if (sprite_q.size() > 0 &&
                    ((n_sent > 120 && n_sent < 200) || $urandom_range(99) >= 7)) begin
                    spr <= sprite_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------- receiver stall
    // Hold off for a long stretch once, so the pipeline fills and the input
    // stalls; otherwise stall at random, with a quiet window of sprites.
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (!hold_done && n_sent == 40) begin
                hold_done <= 1'b1;
                hold_left <= 300;
                out_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_stall <= (hold_left > 1);
            end else if (n_sent > 220 && n_sent < 300) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(99) < 7);
            end
        end
    end

    // -------------------------------------------------------------- monitor
    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH vertex %0d: %s got %0d want %0d", n_seen, what, got, want);
        n_errors++;
    endtask

    always @(posedge clk) begin
        t_vertex w;
        if (rst_n && out_valid && !out_stall) begin
            if (vertex_q.size() == 0) begin
                report_mismatch("unexpected beat, corner", o_corner, -1);
            end else begin
                w = vertex_q.pop_front();
                if (o_corner !== w.corner) report_mismatch("corner", o_corner, w.corner);
                if (o_x !== w.x) report_mismatch("vert_x", o_x, w.x);
                if (o_y !== w.y) report_mismatch("vert_y", o_y, w.y);
                if (o_z !== w.z) report_mismatch("vert_z", o_z, w.z);
                if (o_last !== w.last) report_mismatch("last", o_last, w.last);
            end
            n_seen <= n_seen + 1;
        end
    end

    // ------------------------------------------------------ reset and end
    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done && sprite_q.size() == 0);
        @(posedge clk);
        while (in_valid || vertex_q.size() != 0) @(posedge clk);
        // linger so any extra beat shows up as unexpected
        repeat (60) @(posedge clk);
        if (vertex_q.size() != 0)
            report_mismatch("leftover vertices", vertex_q.size(), 0);
        $display("Sent %0d sprites, checked %0d vertices, incl. pivot code 3,",
                 n_sent, n_seen);
        $display("angle extremes, saturation and a long output hold-off.");
        if (n_errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("timeout");
        $display("testbench NOT OK");
        $finish;
    end

endmodule
